/* rtl/core/skrt_pkg.sv */
`timescale 1ns / 1ps
// Package for the sorted keyed record table.
// Holds the command, status and state codes and the controller/datapath structs.
// Used by skrt_ctrl, skrt_datapath and sorted_keyed_record_table.
package skrt_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned LABEL_BYTES_DEF = 25;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned QTY_W           = 32;
  localparam int unsigned LABEL_MAX_BYTES = 25;
  localparam int unsigned LABEL_W         = 8 * LABEL_MAX_BYTES;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned TAIL_W          = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_ACT,
    S_SH_RD,
    S_SH_WR,
    S_WR_NEW,
    S_UPD,
    S_EM_OK,
    S_EM_DUP,
    S_EM_MISS,
    S_EM_FULL,
    S_DMP_RD,
    S_DMP_EM
  } state_e;

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_PTR,
    RD_PTR_M1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_UPD
  } wr_sel_e;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_NEW,
    SRC_UPD,
    SRC_MISS
  } emit_src_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [QTY_W-1:0]   qty;
    logic [LABEL_W-1:0] label;
  } rec_t;

  typedef struct packed {
    logic      accept;
    logic      bs_step;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      ptr_load_cnt;
    logic      ptr_dec;
    logic      ptr_inc;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      cnt_inc;
    logic      emit;
    emit_src_e emit_src;
    status_e   emit_status;
    logic      emit_last;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic hit;
    logic ptr_gt_lo;
    logic ptr_last;
    logic out_ready;
  } stat_t;

endpackage

/* rtl/core/skrt_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the sorted keyed record table: record memory, search bounds,
// shift pointer, entry count, saturating update and the output register.
// Depends on skrt_pkg.
module skrt_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned LABEL_BYTES = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   cmd_i,
  input  logic signed [31:0]           key_i,
  input  logic signed [31:0]           amount_i,
  input  logic [63:0]                  label_w0_i,
  input  logic [63:0]                  label_w1_i,
  input  logic [63:0]                  label_w2_i,
  input  logic [7:0]                   label_w3_i,
  input  skrt_pkg::ctrl_t              ctrl_i,
  output skrt_pkg::stat_t              stat_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic signed [31:0]           rec_key_o,
  output logic signed [31:0]           quantity_o,
  output logic [63:0]                  rec_w0_o,
  output logic [63:0]                  rec_w1_o,
  output logic [63:0]                  rec_w2_o,
  output logic [7:0]                   rec_w3_o,
  output logic                         last_o
);
  import skrt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cmd_e               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [QTY_W-1:0]   amt_q;
  logic [LABEL_W-1:0] label_q;
  logic [CW-1:0]      lo_q;
  logic [CW-1:0]      hi_q;
  logic [CW-1:0]      ptr_q;
  logic [CW-1:0]      cnt_q;
  rec_t               mem [CAPACITY];
  rec_t               rdata_q;
  logic               out_valid_q;
  rec_t               out_rec_q;
  status_e            out_status_q;
  logic               out_last_q;

  logic [LABEL_W-1:0] label_in;
  logic [LABEL_W-1:0] label_masked;
  logic               keep;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      ptr_m1;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  rec_t               new_rec;
  rec_t               upd_rec;
  rec_t               wdata;
  rec_t               emit_rec;
  logic [QTY_W:0]     qty_sum;
  logic [QTY_W-1:0]   qty_sat;
  logic               out_ready;

  assign label_in = {label_w3_i, label_w2_i, label_w1_i, label_w0_i};

  // A name ends at its first zero byte or at LABEL_BYTES; later bytes are stored as zero.
  always_comb begin
    keep = 1'b1;
    label_masked = '0;
    for (int i = 0; i < LABEL_MAX_BYTES; i++) begin
      keep = keep && (i < LABEL_BYTES) && (label_in[8*i +: 8] != 8'd0);
      label_masked[8*i +: 8] = keep ? label_in[8*i +: 8] : 8'd0;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign ptr_m1  = ptr_q - 1'b1;

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_MID:    raddr = mid[AW-1:0];
      RD_LO:     raddr = lo_q[AW-1:0];
      RD_PTR:    raddr = ptr_q[AW-1:0];
      RD_PTR_M1: raddr = ptr_m1[AW-1:0];
      default:   raddr = lo_q[AW-1:0];
    endcase
  end

  assign qty_sum = {rdata_q.qty[QTY_W-1], rdata_q.qty} + {amt_q[QTY_W-1], amt_q};

  always_comb begin
    if (qty_sum[QTY_W] != qty_sum[QTY_W-1]) begin
      qty_sat = qty_sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
    end else begin
      qty_sat = qty_sum[QTY_W-1:0];
    end
  end

  assign new_rec = '{key: key_q, qty: amt_q, label: label_q};
  assign upd_rec = '{key: rdata_q.key, qty: qty_sat, label: rdata_q.label};

  always_comb begin
    case (ctrl_i.wr_sel)
      WR_SHIFT: begin
        waddr = ptr_q[AW-1:0];
        wdata = rdata_q;
      end
      WR_NEW: begin
        waddr = lo_q[AW-1:0];
        wdata = new_rec;
      end
      WR_UPD: begin
        waddr = lo_q[AW-1:0];
        wdata = upd_rec;
      end
      default: begin
        waddr = lo_q[AW-1:0];
        wdata = new_rec;
      end
    endcase
  end

  always_comb begin
    case (ctrl_i.emit_src)
      SRC_MEM:  emit_rec = rdata_q;
      SRC_NEW:  emit_rec = new_rec;
      SRC_UPD:  emit_rec = upd_rec;
      SRC_MISS: emit_rec = '{key: key_q, qty: '0, label: '0};
      default:  emit_rec = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      key_q   <= key_i;
      amt_q   <= amount_i;
      label_q <= label_masked;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_INSERT;
      lo_q  <= '0;
      hi_q  <= '0;
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.accept) begin
        cmd_q <= cmd_e'(cmd_i);
        lo_q  <= '0;
        hi_q  <= cnt_q;
      end else if (ctrl_i.bs_step) begin
        if ($signed(rdata_q.key) < $signed(key_q)) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end
      if (ctrl_i.accept) begin
        ptr_q <= '0;
      end else if (ctrl_i.ptr_load_cnt) begin
        ptr_q <= cnt_q;
      end else if (ctrl_i.ptr_dec) begin
        ptr_q <= ptr_m1;
      end else if (ctrl_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_rec_q    <= emit_rec;
      out_status_q <= ctrl_i.emit_status;
      out_last_q   <= ctrl_i.emit_last;
    end
  end

  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.full      = (cnt_q == CW'(CAPACITY));
    stat_o.empty     = (cnt_q == '0);
    stat_o.lo_lt_hi  = (lo_q < hi_q);
    stat_o.lo_lt_cnt = (lo_q < cnt_q);
    stat_o.hit       = (lo_q < cnt_q) && (rdata_q.key == key_q);
    stat_o.ptr_gt_lo = (ptr_q > lo_q);
    stat_o.ptr_last  = (ptr_q == cnt_q - 1'b1);
    stat_o.out_ready = out_ready;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign rec_key_o   = out_rec_q.key;
  assign quantity_o  = out_rec_q.qty;
  assign rec_w0_o    = out_rec_q.label[WORD_W-1:0];
  assign rec_w1_o    = out_rec_q.label[2*WORD_W-1:WORD_W];
  assign rec_w2_o    = out_rec_q.label[3*WORD_W-1:2*WORD_W];
  assign rec_w3_o    = out_rec_q.label[3*WORD_W +: TAIL_W];
  assign last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> out_ready)
    else $error("result emitted over an undelivered item");

  a_shift_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr_en && ctrl_i.wr_sel == WR_SHIFT) |-> (ptr_q > lo_q))
    else $error("shift write at or below insertion point");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cnt_inc |-> (cnt_q < CW'(CAPACITY)))
    else $error("insert into a full table");
`endif

endmodule

/* rtl/core/skrt_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the sorted keyed record table.
// Sequences binary search, shift, write, update and dump; depends on skrt_pkg.
module skrt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      cmd_i,
  input  skrt_pkg::stat_t stat_i,
  output skrt_pkg::ctrl_t ctrl_o
);
  import skrt_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   accept;
  cmd_e   cmd_in;

  assign cmd_in = cmd_e'(cmd_i);
  assign accept = (state_q == S_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in)
            CMD_DUMP:   state_d = stat_i.empty ? S_IDLE : S_DMP_RD;
            CMD_INSERT: state_d = stat_i.full ? S_EM_FULL : S_BS_RD;
            default:    state_d = S_BS_RD;
          endcase
        end
      end
      S_BS_RD:  state_d = stat_i.lo_lt_hi ? S_BS_CMP : S_ACT;
      S_BS_CMP: state_d = S_BS_RD;
      S_ACT: begin
        case (stat_i.cmd)
          CMD_INSERT: state_d = stat_i.hit ? S_EM_DUP : S_SH_RD;
          CMD_SEARCH: state_d = stat_i.hit ? S_EM_OK : S_EM_MISS;
          CMD_UPDATE: state_d = stat_i.hit ? S_UPD : S_EM_MISS;
          default:    state_d = S_IDLE;
        endcase
      end
      S_SH_RD:  state_d = stat_i.ptr_gt_lo ? S_SH_WR : S_WR_NEW;
      S_SH_WR:  state_d = S_SH_RD;
      S_WR_NEW, S_UPD, S_EM_OK, S_EM_DUP, S_EM_MISS, S_EM_FULL: begin
        if (stat_i.out_ready) begin
          state_d = S_IDLE;
        end
      end
      S_DMP_RD: state_d = S_DMP_EM;
      S_DMP_EM: begin
        if (stat_i.out_ready) begin
          state_d = stat_i.ptr_last ? S_IDLE : S_DMP_RD;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o             = '0;
    ctrl_o.rd_sel      = RD_LO;
    ctrl_o.wr_sel      = WR_NEW;
    ctrl_o.emit_src    = SRC_MEM;
    ctrl_o.emit_status = ST_OK;
    ctrl_o.emit_last   = 1'b1;
    ctrl_o.accept      = accept;
    case (state_q)
      S_BS_RD: begin
        if (stat_i.lo_lt_hi) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_MID;
        end else begin
          ctrl_o.rd_en  = stat_i.lo_lt_cnt;
          ctrl_o.rd_sel = RD_LO;
        end
      end
      S_BS_CMP: ctrl_o.bs_step = 1'b1;
      S_ACT: begin
        ctrl_o.ptr_load_cnt = (stat_i.cmd == CMD_INSERT) && !stat_i.hit;
      end
      S_SH_RD: begin
        ctrl_o.rd_en  = stat_i.ptr_gt_lo;
        ctrl_o.rd_sel = RD_PTR_M1;
      end
      S_SH_WR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_sel  = WR_SHIFT;
        ctrl_o.ptr_dec = 1'b1;
      end
      S_WR_NEW: begin
        ctrl_o.wr_en    = stat_i.out_ready;
        ctrl_o.wr_sel   = WR_NEW;
        ctrl_o.cnt_inc  = stat_i.out_ready;
        ctrl_o.emit     = stat_i.out_ready;
        ctrl_o.emit_src = SRC_NEW;
      end
      S_UPD: begin
        ctrl_o.wr_en    = stat_i.out_ready;
        ctrl_o.wr_sel   = WR_UPD;
        ctrl_o.emit     = stat_i.out_ready;
        ctrl_o.emit_src = SRC_UPD;
      end
      S_EM_OK: ctrl_o.emit = stat_i.out_ready;
      S_EM_DUP: begin
        ctrl_o.emit        = stat_i.out_ready;
        ctrl_o.emit_status = ST_DUP;
      end
      S_EM_MISS: begin
        ctrl_o.emit        = stat_i.out_ready;
        ctrl_o.emit_src    = SRC_MISS;
        ctrl_o.emit_status = ST_NOTFOUND;
      end
      S_EM_FULL: begin
        ctrl_o.emit        = stat_i.out_ready;
        ctrl_o.emit_src    = SRC_MISS;
        ctrl_o.emit_status = ST_FULL;
      end
      S_DMP_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = RD_PTR;
      end
      S_DMP_EM: begin
        ctrl_o.emit      = stat_i.out_ready;
        ctrl_o.emit_last = stat_i.ptr_last;
        ctrl_o.ptr_inc   = stat_i.out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* rtl/core/sorted_keyed_record_table.sv */
`timescale 1ns / 1ps
// Top level of the sorted keyed record table: controller plus datapath.
// Depends on skrt_pkg, skrt_ctrl and skrt_datapath.
//
//   Channel  Handshake                 Payload
//   input    in_valid_i / in_stall_o   cmd_i key_i amount_i label_w0_i..label_w3_i
//   output   out_valid_o / out_stall_i status_o rec_key_o quantity_o rec_w0_o..rec_w3_o last_o
//
// Search, update and insert run a binary search over the record memory, each halving step
// a read state (S_BS_RD) and then a compare state (S_BS_CMP); an insert then moves each later
// record with a read (S_SH_RD) and a write (S_SH_WR). A dump reads and emits one record at a
// time. The table is empty after reset. A new item is taken in the idle state even while a
// result waits in the output register; emitting states wait for that register to free up.
module sorted_keyed_record_table #(
  parameter int unsigned CAPACITY    = skrt_pkg::CAPACITY_DEF,
  parameter int unsigned LABEL_BYTES = skrt_pkg::LABEL_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] amount_i,
  input  logic [63:0]        label_w0_i,
  input  logic [63:0]        label_w1_i,
  input  logic [63:0]        label_w2_i,
  input  logic [7:0]         label_w3_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] rec_key_o,
  output logic signed [31:0] quantity_o,
  output logic [63:0]        rec_w0_o,
  output logic [63:0]        rec_w1_o,
  output logic [63:0]        rec_w2_o,
  output logic [7:0]         rec_w3_o,
  output logic               last_o
);
  import skrt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  skrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  skrt_datapath #(
    .CAPACITY    (CAPACITY),
    .LABEL_BYTES (LABEL_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .amount_i    (amount_i),
    .label_w0_i  (label_w0_i),
    .label_w1_i  (label_w1_i),
    .label_w2_i  (label_w2_i),
    .label_w3_i  (label_w3_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .rec_key_o   (rec_key_o),
    .quantity_o  (quantity_o),
    .rec_w0_o    (rec_w0_o),
    .rec_w1_o    (rec_w1_o),
    .rec_w2_o    (rec_w2_o),
    .rec_w3_o    (rec_w3_o),
    .last_o      (last_o)
  );

endmodule

/* tb/sorted_keyed_record_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted keyed record table.
// It holds its own sorted table model to predict results, and drives random idles and stalls.
// Depends on skrt_pkg and sorted_keyed_record_table.
module sorted_keyed_record_table_tb;
  import skrt_pkg::*;

  localparam int unsigned TABLE_SIZE = 64;
  localparam int unsigned NAME_BYTES = 25;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    status_e     status;
    logic [31:0] key;
    logic [31:0] qty;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [7:0]  w3;
    logic        last;
  } outcome_t;

  typedef struct packed {
    logic [31:0]  key;
    logic [31:0]  qty;
    logic [199:0] name;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] amount_i = '0;
  logic [63:0] label_w0_i = '0;
  logic [63:0] label_w1_i = '0;
  logic [63:0] label_w2_i = '0;
  logic [7:0] label_w3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic signed [31:0] rec_key_o;
  logic signed [31:0] quantity_o;
  logic [63:0] rec_w0_o;
  logic [63:0] rec_w1_o;
  logic [63:0] rec_w2_o;
  logic [7:0] rec_w3_o;
  logic last_o;

  entry_t table_q[$];
  outcome_t pending_q[$];
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned rx_wait = 0;

  always #10 clk_i = ~clk_i;

  sorted_keyed_record_table dut (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_keyed_record_table regression: fail");
      $finish;
    end
  end

  function automatic logic [199:0] trim_name(logic [63:0] w0, logic [63:0] w1,
                                             logic [63:0] w2, logic [7:0] w3);
    logic [199:0] raw;
    logic [199:0] kept;
    bit ended;
    raw = {w3, w2, w1, w0};
    kept = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) kept[8*i +: 8] = raw[8*i +: 8];
    end
    return kept;
  endfunction

  function automatic outcome_t record_outcome(entry_t e, status_e st, logic lst);
    outcome_t o;
    o.status = st;
    o.key = e.key;
    o.qty = e.qty;
    o.w0 = e.name[63:0];
    o.w1 = e.name[127:64];
    o.w2 = e.name[191:128];
    o.w3 = e.name[199:192];
    o.last = lst;
    return o;
  endfunction

  function automatic outcome_t miss_outcome(status_e st, logic [31:0] k);
    outcome_t o;
    o = '0;
    o.status = st;
    o.key = k;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic void predict_table(cmd_e cmd, logic [31:0] k, logic [31:0] amt,
                                        logic [63:0] w0, logic [63:0] w1,
                                        logic [63:0] w2, logic [7:0] w3);
    int pos;
    bit hit;
    longint sum;
    entry_t e;
    pos = 0;
    while (pos < table_q.size() && $signed(table_q[pos].key) < $signed(k)) pos++;
    hit = (pos < table_q.size()) && (table_q[pos].key == k);
    case (cmd)
      CMD_INSERT: begin
        if (table_q.size() >= TABLE_SIZE) pending_q.push_back(miss_outcome(ST_FULL, k));
        else if (hit) pending_q.push_back(record_outcome(table_q[pos], ST_DUP, 1'b1));
        else begin
          e.key = k;
          e.qty = amt;
          e.name = trim_name(w0, w1, w2, w3);
          table_q.insert(pos, e);
          pending_q.push_back(record_outcome(e, ST_OK, 1'b1));
        end
      end
      CMD_SEARCH, CMD_UPDATE: begin
        if (!hit) pending_q.push_back(miss_outcome(ST_NOTFOUND, k));
        else begin
          if (cmd == CMD_UPDATE) begin
            sum = longint'($signed(table_q[pos].qty)) + longint'($signed(amt));
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            table_q[pos].qty = sum[31:0];
          end
          pending_q.push_back(record_outcome(table_q[pos], ST_OK, 1'b1));
        end
      end
      default: begin
        foreach (table_q[i])
          pending_q.push_back(record_outcome(table_q[i], ST_OK, i == table_q.size() - 1));
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_e'(status_o), rec_key_o, quantity_o, rec_w0_o, rec_w1_o, rec_w2_o,
             rec_w3_o, last_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h.", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, got %h.", want, got);
        end
      end
    end
  end

  // The receiver stalls for a randomly drawn wait after each item it takes, or holds off on request.
  always @(posedge clk_i) begin
    int unsigned draw;
    draw = $urandom_range(0, 4);
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait > 0) begin
      out_stall_i <= (rx_wait > 1);
      rx_wait <= rx_wait - 1;
    end else if (out_valid_o && !out_stall_i) begin
      out_stall_i <= (draw != 0);
      rx_wait <= draw;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_item(cmd_e cmd, logic [31:0] k, logic [31:0] amt,
                           logic [63:0] w0 = '0, logic [63:0] w1 = '0,
                           logic [63:0] w2 = '0, logic [7:0] w3 = '0);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= k;
    amount_i <= amt;
    label_w0_i <= w0;
    label_w1_i <= w1;
    label_w2_i <= w2;
    label_w3_i <= w3;
    do @(posedge clk_i); while (in_stall_o);
    predict_table(cmd, k, amt, w0, w1, w2, w3);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  function automatic logic [31:0] table_key();
    if (table_q.size() != 0 && $urandom_range(0, 2) != 0)
      return table_q[$urandom_range(0, table_q.size() - 1)].key;
    return $urandom_range(0, 3) == 0 ? rand_word() : 32'($signed($urandom_range(0, 40)) - 20);
  endfunction

  task automatic send_random_insert(logic [31:0] k);
    send_item(CMD_INSERT, k, rand_word(), {rand_word(), rand_word()},
              {rand_word(), rand_word()}, {rand_word(), rand_word()}, 8'($urandom()));
  endtask

  task automatic test_directed();
    send_item(CMD_DUMP, 32'd0, 32'd0);
    send_item(CMD_SEARCH, 32'd5, 32'd0);
    send_item(CMD_UPDATE, 32'h8000_0000, 32'd1);
    send_item(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_fff0, '1, '1, '1, 8'hff);
    send_item(CMD_INSERT, 32'h8000_0000, 32'h8000_0005, 64'h0000_4142, '1, '1, 8'h11);
    send_item(CMD_INSERT, 32'd0, 32'd0, 64'h4847_4645_4443_4241, 64'h00ff_3231,
              64'hffff, 8'h7);
    send_item(CMD_INSERT, 32'hffff_ffff, 32'd1, '0, '1, '1, 8'hff);
    send_item(CMD_INSERT, 32'd0, 32'd9, 64'h61);
    send_item(CMD_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_UPDATE, 32'd0, 32'h7fff_ffff);
    send_item(CMD_UPDATE, 32'd0, 32'h8000_0000);
    send_item(CMD_UPDATE, 32'hffff_ffff, 32'hffff_fffe);
    send_item(CMD_SEARCH, 32'hffff_ffff, 32'd0);
    send_item(CMD_SEARCH, 32'd1, 32'd0);
    send_item(CMD_DUMP, 32'd0, 32'd0);
  endtask

  task automatic test_fill_table();
    while (table_q.size() < TABLE_SIZE) send_random_insert(rand_word());
    send_random_insert(rand_word());
    send_random_insert(table_q[3].key);
    send_item(CMD_DUMP, 32'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles <= 400;
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_item(CMD_SEARCH, table_key(), 32'd0);
    send_item(CMD_DUMP, 32'd0, 32'd0);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // The table is full by now, so the random phase mixes rejected inserts with
  // searches, updates and occasional dumps.
  task automatic test_random_mix();
    int unsigned sel;
    for (int n = 0; n < 335; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 6) send_random_insert(table_key());
      else if (sel < 11) send_item(CMD_SEARCH, table_key(), rand_word());
      else if (sel < 18) begin
        send_item(CMD_UPDATE, table_key(), $urandom_range(0, 1) ? rand_word() :
                  32'($signed($urandom_range(0, 2000)) - 1000));
      end else if (sel == 18 && $urandom_range(0, 3) == 0) send_item(CMD_DUMP, 32'd0, 32'd0);
      else send_item(CMD_SEARCH, rand_word(), 32'd0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_backpressure();
    test_random_mix();
    send_item(CMD_DUMP, 32'd0, 32'd0);
    wait_drained();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("sorted_keyed_record_table regression: pass");
    end else begin
      $display("sorted_keyed_record_table regression: fail");
    end
    $finish;
  end

endmodule
